### hdl/ordered_list_insert_update_delete_unit_assert.svh
// assertion macros shared by the list unit modules
// expects i_clk and i_rst_n in the module that uses them
`ifndef ORDERED_LIST_INSERT_UPDATE_DELETE_UNIT_ASSERT_SVH
`define ORDERED_LIST_INSERT_UPDATE_DELETE_UNIT_ASSERT_SVH

// same-cycle implication
`define OLIUD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("list unit assertion failed");

// next-cycle implication
`define OLIUD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("list unit assertion failed");

`endif

### hdl/oliud_pkg.sv
// types, codes and microprogram table for the ordered list unit
// no dependencies
`timescale 1ns / 1ps

package oliud_pkg;

    localparam int CNT_W  = 6;
    localparam int DATA_W = 32;
    localparam int PC_W   = 4;
    localparam int APB_AW = 3;

    typedef logic [1:0]      t_kind;
    typedef logic [1:0]      t_status;
    typedef logic [PC_W-1:0] t_pc;
    typedef logic [2:0]      t_cond;
    typedef logic [1:0]      t_ptr_op;
    typedef logic [1:0]      t_wr_op;
    typedef logic [1:0]      t_rd_op;
    typedef logic [1:0]      t_cnt_op;
    typedef logic [1:0]      t_emit;

    localparam t_kind KIND_APPEND = 2'd0;
    localparam t_kind KIND_UPDATE = 2'd1;
    localparam t_kind KIND_DELETE = 2'd2;
    localparam t_kind KIND_DUMP   = 2'd3;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_BADPOS = 2'd2;
    localparam t_status ST_EMPTY  = 2'd3;

    localparam logic REG_CAPACITY = 1'b0;

    localparam t_cond COND_ALWAYS    = 3'd0;
    localparam t_cond COND_FULL      = 3'd1;
    localparam t_cond COND_BADPOS    = 3'd2;
    localparam t_cond COND_EMPTY     = 3'd3;
    localparam t_cond COND_SHIFT_END = 3'd4;
    localparam t_cond COND_LAST      = 3'd5;

    localparam t_ptr_op PTR_KEEP = 2'd0;
    localparam t_ptr_op PTR_POS  = 2'd1;
    localparam t_ptr_op PTR_ZERO = 2'd2;
    localparam t_ptr_op PTR_INC  = 2'd3;

    localparam t_wr_op WR_NONE   = 2'd0;
    localparam t_wr_op WR_APPEND = 2'd1;
    localparam t_wr_op WR_UPDATE = 2'd2;
    localparam t_wr_op WR_SHIFT  = 2'd3;

    localparam t_rd_op RD_NONE = 2'd0;
    localparam t_rd_op RD_PTR  = 2'd1;
    localparam t_rd_op RD_NEXT = 2'd2;

    localparam t_cnt_op CNT_KEEP = 2'd0;
    localparam t_cnt_op CNT_INC  = 2'd1;
    localparam t_cnt_op CNT_DEC  = 2'd2;

    localparam t_emit EM_NONE   = 2'd0;
    localparam t_emit EM_STATUS = 2'd1;
    localparam t_emit EM_ENTRY  = 2'd2;

    localparam t_pc PC_FETCH    = 4'd0;
    localparam t_pc PC_APP0     = 4'd1;
    localparam t_pc PC_APP1     = 4'd2;
    localparam t_pc PC_UPD0     = 4'd3;
    localparam t_pc PC_UPD1     = 4'd4;
    localparam t_pc PC_DEL0     = 4'd5;
    localparam t_pc PC_DEL1     = 4'd6;
    localparam t_pc PC_DEL2     = 4'd7;
    localparam t_pc PC_DEL3     = 4'd8;
    localparam t_pc PC_DMP0     = 4'd9;
    localparam t_pc PC_DMP1     = 4'd10;
    localparam t_pc PC_DMP2     = 4'd11;
    localparam t_pc PC_S_FULL   = 4'd12;
    localparam t_pc PC_S_BADPOS = 4'd13;
    localparam t_pc PC_S_EMPTY  = 4'd14;

    typedef struct packed {
        logic    wait_in;
        logic    dispatch;
        t_cond   cond;
        t_pc     jt;
        t_pc     jf;
        t_ptr_op ptr_op;
        t_wr_op  wr_op;
        t_rd_op  rd_op;
        t_cnt_op cnt_op;
        t_emit   emit;
        t_status status;
    } t_uword;

    typedef struct packed {
        logic    latch;
        t_ptr_op ptr_op;
        t_wr_op  wr_op;
        t_rd_op  rd_op;
        t_cnt_op cnt_op;
        t_emit   emit;
        t_status status;
    } t_ctrl;

    typedef struct packed {
        logic full;
        logic badpos;
        logic empty;
        logic shift_end;
        logic last;
        logic out_free;
    } t_flags;

    localparam t_uword UW_NOP = '0;

    function automatic t_uword oliud_rom(input t_pc pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            PC_FETCH: begin
                w.wait_in  = 1'b1;
                w.dispatch = 1'b1;
            end
            PC_APP0: begin
                w.cond = COND_FULL;
                w.jt   = PC_S_FULL;
                w.jf   = PC_APP1;
            end
            PC_APP1: begin
                w.wr_op  = WR_APPEND;
                w.cnt_op = CNT_INC;
                w.emit   = EM_STATUS;
                w.status = ST_OK;
            end
            PC_UPD0: begin
                w.cond = COND_BADPOS;
                w.jt   = PC_S_BADPOS;
                w.jf   = PC_UPD1;
            end
            PC_UPD1: begin
                w.wr_op  = WR_UPDATE;
                w.emit   = EM_STATUS;
                w.status = ST_OK;
            end
            PC_DEL0: begin
                w.cond   = COND_BADPOS;
                w.jt     = PC_S_BADPOS;
                w.jf     = PC_DEL1;
                w.ptr_op = PTR_POS;
            end
            PC_DEL1: begin
                w.cond  = COND_SHIFT_END;
                w.jt    = PC_DEL3;
                w.jf    = PC_DEL2;
                w.rd_op = RD_NEXT;
            end
            PC_DEL2: begin
                w.jt     = PC_DEL1;
                w.wr_op  = WR_SHIFT;
                w.ptr_op = PTR_INC;
            end
            PC_DEL3: begin
                w.cnt_op = CNT_DEC;
                w.emit   = EM_STATUS;
                w.status = ST_OK;
            end
            PC_DMP0: begin
                w.cond   = COND_EMPTY;
                w.jt     = PC_S_EMPTY;
                w.jf     = PC_DMP1;
                w.ptr_op = PTR_ZERO;
            end
            PC_DMP1: begin
                w.jt    = PC_DMP2;
                w.rd_op = RD_PTR;
            end
            PC_DMP2: begin
                w.cond   = COND_LAST;
                w.jt     = PC_FETCH;
                w.jf     = PC_DMP1;
                w.ptr_op = PTR_INC;
                w.emit   = EM_ENTRY;
            end
            PC_S_FULL: begin
                w.emit   = EM_STATUS;
                w.status = ST_FULL;
            end
            PC_S_BADPOS: begin
                w.emit   = EM_STATUS;
                w.status = ST_BADPOS;
            end
            PC_S_EMPTY: begin
                w.emit   = EM_STATUS;
                w.status = ST_EMPTY;
            end
            default: begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

    function automatic t_pc oliud_dispatch(input t_kind kind);
        t_pc pc;
        unique case (kind)
            KIND_APPEND: pc = PC_APP0;
            KIND_UPDATE: pc = PC_UPD0;
            KIND_DELETE: pc = PC_DEL0;
            KIND_DUMP:   pc = PC_DMP0;
            default:     pc = PC_FETCH;
        endcase
        return pc;
    endfunction

endpackage

### hdl/oliud_sequencer.sv
// microprogram sequencer: step counter, control table lookup, jumps
// depends on oliud_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ordered_list_insert_update_delete_unit_assert.svh"

module oliud_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  oliud_pkg::t_kind   i_req_type,
    input  oliud_pkg::t_flags  i_flags,
    output oliud_pkg::t_ctrl   o_ctrl
);
    import oliud_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w;
    logic   cond_val;
    logic   go;

    assign w          = oliud_rom(r_pc);
    assign o_in_stall = !w.wait_in;
    assign go         = ((w.emit == EM_NONE) || i_flags.out_free) &&
                        (!w.wait_in || i_in_valid);

    always_comb begin
        unique case (w.cond)
            COND_ALWAYS:    cond_val = 1'b1;
            COND_FULL:      cond_val = i_flags.full;
            COND_BADPOS:    cond_val = i_flags.badpos;
            COND_EMPTY:     cond_val = i_flags.empty;
            COND_SHIFT_END: cond_val = i_flags.shift_end;
            COND_LAST:      cond_val = i_flags.last;
            default:        cond_val = 1'b1;
        endcase
    end

    always_comb begin
        if (!go) begin
            n_pc = r_pc;
        end else if (w.dispatch) begin
            n_pc = oliud_dispatch(i_req_type);
        end else begin
            n_pc = cond_val ? w.jt : w.jf;
        end
    end

    always_comb begin
        o_ctrl = '0;
        if (go) begin
            o_ctrl.latch  = w.wait_in;
            o_ctrl.ptr_op = w.ptr_op;
            o_ctrl.wr_op  = w.wr_op;
            o_ctrl.rd_op  = w.rd_op;
            o_ctrl.cnt_op = w.cnt_op;
            o_ctrl.emit   = w.emit;
            o_ctrl.status = w.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    `OLIUD_ASSERT_NXT(a_leave_fetch, i_in_valid && !o_in_stall, r_pc != PC_FETCH)

endmodule

### hdl/oliud_datapath.sv
// list datapath: entry memory, count and pointer registers, result register
// depends on oliud_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ordered_list_insert_update_delete_unit_assert.svh"

module oliud_datapath #(
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  oliud_pkg::t_ctrl                     i_ctrl,
    output oliud_pkg::t_flags                    o_flags,
    input  logic [oliud_pkg::CNT_W-1:0]          i_capacity,
    input  logic [oliud_pkg::CNT_W-1:0]          i_position,
    input  logic signed [oliud_pkg::DATA_W-1:0]  i_data_in,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output oliud_pkg::t_status                   o_status,
    output logic signed [oliud_pkg::DATA_W-1:0]  o_data_out,
    output logic [oliud_pkg::CNT_W-1:0]          o_out_position,
    output logic                                 o_last,
    output logic [oliud_pkg::CNT_W-1:0]          o_count_now
);
    import oliud_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W:0] DEPTH_X = (CNT_W + 1)'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  n_ptr;
    logic [DATA_W-1:0] r_rdata;

    logic              r_out_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_data_out;
    logic [CNT_W-1:0]  r_out_pos;
    logic              r_last;
    logic [CNT_W-1:0]  r_count_now;

    logic [CNT_W-1:0]  ptr_inc;
    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W:0]    ptr_inc_x;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    assign ptr_inc   = r_ptr + 1'b1;
    assign pos_m1    = r_pos - 1'b1;
    assign ptr_inc_x = {1'b0, r_ptr} + 1'b1;

    assign o_flags.full      = ({1'b0, r_count} >= DEPTH_X) || (r_count >= i_capacity);
    assign o_flags.badpos    = (r_pos == '0) || (r_pos > r_count);
    assign o_flags.empty     = (r_count == '0);
    assign o_flags.shift_end = (ptr_inc_x >= {1'b0, r_count});
    assign o_flags.last      = (ptr_inc_x == {1'b0, r_count});
    assign o_flags.out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        wr_en   = (i_ctrl.wr_op != WR_NONE);
        wr_addr = r_ptr[AW-1:0];
        wr_data = r_rdata;
        case (i_ctrl.wr_op)
            WR_APPEND: begin
                wr_addr = r_count[AW-1:0];
                wr_data = r_data;
            end
            WR_UPDATE: begin
                wr_addr = pos_m1[AW-1:0];
                wr_data = r_data;
            end
            default: begin
                wr_addr = r_ptr[AW-1:0];
                wr_data = r_rdata;
            end
        endcase
    end

    assign rd_en   = (i_ctrl.rd_op != RD_NONE);
    assign rd_addr = (i_ctrl.rd_op == RD_NEXT) ? ptr_inc[AW-1:0] : r_ptr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_comb begin
        case (i_ctrl.cnt_op)
            CNT_INC: n_count = r_count + 1'b1;
            CNT_DEC: n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        case (i_ctrl.ptr_op)
            PTR_POS:  n_ptr = pos_m1;
            PTR_ZERO: n_ptr = '0;
            PTR_INC:  n_ptr = ptr_inc;
            default:  n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_ctrl.emit != EM_NONE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_ctrl.latch) begin
            r_pos  <= i_position;
            r_data <= i_data_in;
        end
        if (i_ctrl.emit == EM_ENTRY) begin
            r_status    <= ST_OK;
            r_data_out  <= r_rdata;
            r_out_pos   <= ptr_inc;
            r_last      <= o_flags.last;
            r_count_now <= r_count;
        end else if (i_ctrl.emit == EM_STATUS) begin
            r_status    <= i_ctrl.status;
            r_data_out  <= '0;
            r_out_pos   <= '0;
            r_last      <= 1'b1;
            r_count_now <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_data_out     = r_data_out;
    assign o_out_position = r_out_pos;
    assign o_last         = r_last;
    assign o_count_now    = r_count_now;

    `OLIUD_ASSERT_IMP(a_no_inc_full, i_ctrl.cnt_op == CNT_INC, !o_flags.full)
    `OLIUD_ASSERT_IMP(a_emit_slot_free, i_ctrl.emit != EM_NONE, o_flags.out_free)
    `OLIUD_ASSERT_NXT(a_count_hold, i_ctrl.cnt_op == CNT_KEEP, $stable(r_count))

endmodule

### hdl/ordered_list_insert_update_delete_unit.sv
// top level of the ordered list unit: register port, sequencer and datapath
// depends on oliud_pkg, oliud_sequencer and oliud_datapath
//
// Packed list of up to DEPTH signed 32-bit entries with append, update, delete
// and dump requests, one request in work at a time. A request is taken only
// while the sequencer waits in its fetch step; the next one can be taken the
// cycle after the current one puts its last result in the output register.
// Append, update, every rejected request and a dump of an empty list run a
// check step and then a status step. Delete at position p moves count - p
// entries and a dump emits count entries: each entry moved or emitted costs
// one memory read step and one write or emit step of the microprogram, since
// the entry memory has one read and one write port. A stalled output holds the
// sequencer in its emit step. The capacity register sits at byte address 0,
// resets to 32 and acts as DEPTH when set above it; a capacity below the
// current count only blocks appends. Write it only while no request is in work.

`timescale 1ns / 1ps

module ordered_list_insert_update_delete_unit #(
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [oliud_pkg::APB_AW-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_req_type,
    input  logic [oliud_pkg::CNT_W-1:0]          i_position,
    input  logic signed [oliud_pkg::DATA_W-1:0]  i_data_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_status,
    output logic signed [oliud_pkg::DATA_W-1:0]  o_data_out,
    output logic [oliud_pkg::CNT_W-1:0]          o_out_position,
    output logic                                 o_last,
    output logic [oliud_pkg::CNT_W-1:0]          o_count_now
);
    import oliud_pkg::*;

    logic [CNT_W-1:0] r_capacity;
    logic             cfg_wr;
    t_ctrl            ctrl;
    t_flags           flags;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CNT_W'(32);
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CNT_W){1'b0}}, r_capacity} : '0;

    oliud_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req_type (i_req_type),
        .i_flags    (flags),
        .o_ctrl     (ctrl)
    );

    oliud_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_flags        (flags),
        .i_capacity     (r_capacity),
        .i_position     (i_position),
        .i_data_in      (i_data_in),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_data_out     (o_data_out),
        .o_out_position (o_out_position),
        .o_last         (o_last),
        .o_count_now    (o_count_now)
    );

endmodule
